[hdl/assert_macros.svh]
// Assertion helpers used by the checker file rss_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled at the rising clock edge, muted while reset is low.
`define RSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check sampled at every rising clock edge, reset included.
`define RSS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/rss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

  // Fixed field widths
  localparam int RANGE_IN_W  = 16;
  localparam int POINT_W     = 32;
  localparam int IDX_OUT_W   = 10;
  localparam int NUM_W       = 8;
  localparam int CNT_W       = 10;
  localparam int ANG_W       = 16;
  localparam int THR_W       = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // Pipeline depth from input register to result register
  localparam int NUM_STAGES = 7;

  // Quarter-turn sine polynomial coefficients, Q30
  localparam logic [30:0] POLY_A = 31'd1686629713;
  localparam logic [29:0] POLY_B = 30'd688904867;
  localparam logic [26:0] POLY_C = 27'd76016977;

  // One quarter turn in binary angle units
  localparam logic [14:0] QUARTER = 15'd16384;

  // Clustering limits
  localparam logic [CNT_W-1:0] MIN_PAIRS = 10'd2;
  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

  // Register reset values
  localparam logic [THR_W-1:0] THRESHOLD_RST = 16'd100;
  localparam logic [ANG_W-1:0] STEP_RST      = 16'd182;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLOSE_THRESHOLD = 3'd0,
    CFG_POSE_X          = 3'd1,
    CFG_POSE_Y          = 3'd2,
    CFG_POSE_HEADING    = 3'd3,
    CFG_ANGLE_STEP      = 3'd4
  } cfg_reg_t;

  // One enable per pipeline stage, stage 1 in bit 0
  typedef logic [NUM_STAGES-1:0] stage_en_t;

  // Index and cluster fields that ride along with each sample
  typedef struct packed {
    logic [IDX_OUT_W-1:0] idx;
    logic                 closed;
    logic [IDX_OUT_W-1:0] first;
    logic [IDX_OUT_W-1:0] last;
    logic [NUM_W-1:0]     num;
  } side_t;

endpackage

`default_nettype wire

[hdl/rss_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rss_in_if;
  logic                         valid;
  logic                         ready;
  logic [rss_pkg::RANGE_IN_W-1:0] range_mm;
  logic                         last_sample;

  modport source (output valid, range_mm, last_sample, input ready);
  modport sink   (input valid, range_mm, last_sample, output ready);
endinterface

`default_nettype wire

[hdl/rss_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rss_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rss_pkg::POINT_W-1:0]  point_x_mm;
  logic signed [rss_pkg::POINT_W-1:0]  point_y_mm;
  logic [rss_pkg::IDX_OUT_W-1:0]       sample_index;
  logic                                cluster_closed;
  logic [rss_pkg::IDX_OUT_W-1:0]       cluster_first;
  logic [rss_pkg::IDX_OUT_W-1:0]       cluster_last;
  logic [rss_pkg::NUM_W-1:0]           cluster_number;

  modport source (output valid, point_x_mm, point_y_mm, sample_index, cluster_closed,
                  cluster_first, cluster_last, cluster_number, input ready);
  modport sink   (input valid, point_x_mm, point_y_mm, sample_index, cluster_closed,
                  cluster_first, cluster_last, cluster_number, output ready);
endinterface

`default_nettype wire

[hdl/rss_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rss_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rss_pkg::CFG_INDEX_W-1:0]  index;
  logic [rss_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/rss_axis.sv]
`timescale 1ns / 1ps
`default_nettype none

// One world axis: sine of (angle + PHASE) by quarter polynomial, scale by
// range, add pose and saturate. Stages 2..7 of the pipeline.
module rss_axis #(
  parameter int              RNG_W  = 16,
  parameter int              FRAC_W = 15,
  parameter logic [15:0]     PHASE  = 16'd0
) (
  input  wire logic                            clk,
  input  wire rss_pkg::stage_en_t              en,
  input  wire logic [rss_pkg::ANG_W-1:0]       ang,
  input  wire logic [RNG_W-1:0]                range_mm,
  input  wire logic signed [rss_pkg::POINT_W-1:0] pose,
  output logic signed [rss_pkg::POINT_W-1:0]   point
);
  import rss_pkg::*;

  localparam int PROD_W = RNG_W + FRAC_W + 1;
  localparam int SUM_W  = POINT_W + 2;

  // Stage 2: fold into first quadrant, square
  logic [ANG_W-1:0] a_phase;
  logic [14:0]      q_fold;
  logic [29:0]      q_sq;
  logic [14:0]      q_2_r, q_3_r, q_4_r;
  logic [30:0]      x2_2_r, x2_3_r;
  logic             neg_2_r, neg_3_r, neg_4_r, neg_5_r, neg_6_r;
  logic [RNG_W-1:0] rng_2_r, rng_3_r, rng_4_r, rng_5_r;

  always_comb begin
    a_phase = ang + PHASE;
    if (a_phase[14]) begin
      q_fold = QUARTER - {1'b0, a_phase[13:0]};
    end else begin
      q_fold = {1'b0, a_phase[13:0]};
    end
    q_sq = 30'(q_fold) * 30'(q_fold);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q_2_r   <= q_fold;
      x2_2_r  <= 31'({q_sq, 2'b00});
      neg_2_r <= a_phase[15];
      rng_2_r <= range_mm;
    end
  end

  // Stage 3: inner term B - x2*C
  logic [57:0] prod1;
  logic [29:0] t1_3_r;

  assign prod1 = 58'(x2_2_r) * 58'(POLY_C);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t1_3_r  <= POLY_B - 30'(prod1[57:30]);
      x2_3_r  <= x2_2_r;
      q_3_r   <= q_2_r;
      neg_3_r <= neg_2_r;
      rng_3_r <= rng_2_r;
    end
  end

  // Stage 4: outer term A - x2*t1
  logic [60:0] prod2;
  logic [30:0] t_4_r;

  assign prod2 = 61'(x2_3_r) * 61'(t1_3_r);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      t_4_r   <= POLY_A - prod2[60:30];
      q_4_r   <= q_3_r;
      neg_4_r <= neg_3_r;
      rng_4_r <= rng_3_r;
    end
  end

  // Stage 5: x*t, round to FRAC_W fraction bits
  logic [45:0]       prod3;
  logic [31:0]       sin_rnd;
  logic [FRAC_W:0]   mag_5_r;

  always_comb begin
    prod3   = 46'(q_4_r) * 46'(t_4_r);
    sin_rnd = prod3[45:14] + (32'd1 << (29 - FRAC_W));
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      mag_5_r <= sin_rnd[30:30-FRAC_W];
      neg_5_r <= neg_4_r;
      rng_5_r <= rng_4_r;
    end
  end

  // Stage 6: range times magnitude, round half away from zero
  logic [PROD_W-1:0] prod4;
  logic [PROD_W-1:0] prod4_rnd;
  logic [RNG_W:0]    r_6_r;

  always_comb begin
    prod4     = PROD_W'(rng_5_r) * PROD_W'(mag_5_r);
    prod4_rnd = prod4 + (PROD_W'(1) << (FRAC_W - 1));
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      r_6_r   <= prod4_rnd[PROD_W-1:FRAC_W];
      neg_6_r <= neg_5_r;
    end
  end

  // Stage 7: add pose, saturate to 32 bits
  logic signed [SUM_W-1:0] pose_ext;
  logic signed [SUM_W-1:0] r_ext;
  logic signed [SUM_W-1:0] sum;
  logic signed [POINT_W-1:0] point_nxt;
  logic signed [POINT_W-1:0] point_r;

  always_comb begin
    pose_ext = SUM_W'(pose);
    r_ext    = $signed(SUM_W'(r_6_r));
    if (neg_6_r) begin
      sum = pose_ext - r_ext;
    end else begin
      sum = pose_ext + r_ext;
    end
    if (sum[SUM_W-1] == 1'b0 && sum[SUM_W-2:POINT_W-1] != '0) begin
      point_nxt = {1'b0, {(POINT_W-1){1'b1}}};
    end else if (sum[SUM_W-1] == 1'b1 && sum[SUM_W-2:POINT_W-1] != '1) begin
      point_nxt = {1'b1, {(POINT_W-1){1'b0}}};
    end else begin
      point_nxt = sum[POINT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      point_r <= point_nxt;
    end
  end

  assign point = point_r;

endmodule

`default_nettype wire

[hdl/range_scan_segmenter.sv]
// Throughput: one beat per cycle while out_ch.ready is high; each accepted input
// beat passes through the 7-stage pipeline (input register, fold and square, three
// polynomial multiplies, the range scale and the pose add) to its result beat on out_ch.
// Backpressure: in_ch.ready drops only when all 7 stages are full and out_ch.ready is low.
// Reset (rst_n low, synchronous): pipeline emptied, scan state cleared,
// registers back to defaults. No clearing pass; ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module range_scan_segmenter #(
  parameter int MAX_SAMPLES    = 1024,
  parameter int RANGE_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rss_in_if.sink      in_ch,
  rss_out_if.source   out_ch,
  rss_cfg_if.sink     cfg_ch
);
  import rss_pkg::*;

  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int RNG_W = (RANGE_BITS < RANGE_IN_W) ? RANGE_BITS : RANGE_IN_W;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_SAMPLES - 1);

  // Configuration registers
  logic [THR_W-1:0]          thr_r;
  logic signed [POINT_W-1:0] pose_x_r;
  logic signed [POINT_W-1:0] pose_y_r;
  logic [ANG_W-1:0]          heading_r;
  logic [ANG_W-1:0]          step_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RST;
      pose_x_r  <= '0;
      pose_y_r  <= '0;
      heading_r <= '0;
      step_r    <= STEP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        CFG_CLOSE_THRESHOLD: thr_r     <= cfg_ch.data[THR_W-1:0];
        CFG_POSE_X:          pose_x_r  <= $signed(cfg_ch.data);
        CFG_POSE_Y:          pose_y_r  <= $signed(cfg_ch.data);
        CFG_POSE_HEADING:    heading_r <= cfg_ch.data[ANG_W-1:0];
        CFG_ANGLE_STEP:      step_r    <= cfg_ch.data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or its successor moves
  logic [NUM_STAGES-1:0] valid_r;
  stage_en_t             en;

  always_comb begin
    en[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  logic accept;
  assign in_ch.ready = en[0];
  assign accept      = in_ch.valid && en[0];

  // Scan state
  logic [RNG_W-1:0] prev_range_r, prev_range_nxt;
  logic [IDX_W-1:0] sample_cnt_r, sample_cnt_nxt;
  logic [CNT_W-1:0] pair_cnt_r, pair_cnt_nxt;
  logic [IDX_W-1:0] run_start_r, run_start_nxt;
  logic [NUM_W-1:0] clus_cnt_r, clus_cnt_nxt;

  logic [RNG_W-1:0] rng;
  logic [RNG_W-1:0] diff;
  logic             is_close;
  logic             brk_closed;
  logic [CNT_W-1:0] pair_upd;
  logic [IDX_W-1:0] run_upd;
  logic [NUM_W-1:0] clus_upd;
  side_t            side_in;
  logic [IDX_W+ANG_W-1:0] ang_prod;
  logic [ANG_W-1:0]       ang_in;

  // Evaluate the pair, close clusters, advance scan state
  always_comb begin
    rng      = in_ch.range_mm[RNG_W-1:0];
    ang_prod = (IDX_W+ANG_W)'(sample_cnt_r) * (IDX_W+ANG_W)'(step_r);
    ang_in   = heading_r + ang_prod[ANG_W-1:0];

    if (rng > prev_range_r) begin
      diff = rng - prev_range_r;
    end else begin
      diff = prev_range_r - rng;
    end
    is_close   = THR_W'(diff) < thr_r;
    brk_closed = (sample_cnt_r != '0) && !is_close && (pair_cnt_r > MIN_PAIRS);

    pair_upd = pair_cnt_r;
    run_upd  = run_start_r;
    clus_upd = clus_cnt_r;
    if (sample_cnt_r != '0) begin
      if (is_close) begin
        if (pair_cnt_r < COUNT_MAX) begin
          pair_upd = pair_cnt_r + 1'b1;
        end
      end else begin
        pair_upd = '0;
        run_upd  = sample_cnt_r;
        if (brk_closed) begin
          clus_upd = clus_cnt_r + 1'b1;
        end
      end
    end

    side_in.idx    = IDX_OUT_W'(sample_cnt_r);
    side_in.closed = 1'b0;
    side_in.first  = '0;
    side_in.last   = '0;
    side_in.num    = '0;
    if (brk_closed) begin
      side_in.closed = 1'b1;
      side_in.first  = IDX_OUT_W'(run_start_r);
      side_in.last   = IDX_OUT_W'(sample_cnt_r - 1'b1);
      side_in.num    = clus_cnt_r;
    end else if (in_ch.last_sample && pair_upd > MIN_PAIRS) begin
      side_in.closed = 1'b1;
      side_in.first  = IDX_OUT_W'(run_upd);
      side_in.last   = IDX_OUT_W'(sample_cnt_r);
      side_in.num    = clus_upd;
    end

    if (in_ch.last_sample) begin
      prev_range_nxt = '0;
      sample_cnt_nxt = '0;
      pair_cnt_nxt   = '0;
      run_start_nxt  = '0;
      clus_cnt_nxt   = '0;
    end else begin
      prev_range_nxt = rng;
      sample_cnt_nxt = (sample_cnt_r != IDX_MAX) ? sample_cnt_r + 1'b1 : sample_cnt_r;
      pair_cnt_nxt   = pair_upd;
      run_start_nxt  = run_upd;
      clus_cnt_nxt   = clus_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_range_r <= '0;
      sample_cnt_r <= '0;
      pair_cnt_r   <= '0;
      run_start_r  <= '0;
      clus_cnt_r   <= '0;
    end else if (accept) begin
      prev_range_r <= prev_range_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      pair_cnt_r   <= pair_cnt_nxt;
      run_start_r  <= run_start_nxt;
      clus_cnt_r   <= clus_cnt_nxt;
    end
  end

  // Valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  // Stage 1 payload and side fields along the pipeline
  logic [ANG_W-1:0] ang_1_r;
  logic [RNG_W-1:0] rng_1_r;
  side_t            side_r [NUM_STAGES];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ang_1_r   <= ang_in;
      rng_1_r   <= rng;
      side_r[0] <= side_in;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // World x from cosine, world y from sine
  logic signed [POINT_W-1:0] point_x;
  logic signed [POINT_W-1:0] point_y;

  rss_axis #(
    .RNG_W  (RNG_W),
    .FRAC_W (TRIG_FRAC_BITS),
    .PHASE  (16'd16384)
  ) u_axis_x (
    .clk      (clk),
    .en       (en),
    .ang      (ang_1_r),
    .range_mm (rng_1_r),
    .pose     (pose_x_r),
    .point    (point_x)
  );

  rss_axis #(
    .RNG_W  (RNG_W),
    .FRAC_W (TRIG_FRAC_BITS),
    .PHASE  (16'd0)
  ) u_axis_y (
    .clk      (clk),
    .en       (en),
    .ang      (ang_1_r),
    .range_mm (rng_1_r),
    .pose     (pose_y_r),
    .point    (point_y)
  );

  // Result beat
  assign out_ch.valid          = valid_r[NUM_STAGES-1];
  assign out_ch.point_x_mm     = point_x;
  assign out_ch.point_y_mm     = point_y;
  assign out_ch.sample_index   = side_r[NUM_STAGES-1].idx;
  assign out_ch.cluster_closed = side_r[NUM_STAGES-1].closed;
  assign out_ch.cluster_first  = side_r[NUM_STAGES-1].first;
  assign out_ch.cluster_last   = side_r[NUM_STAGES-1].last;
  assign out_ch.cluster_number = side_r[NUM_STAGES-1].num;

endmodule

`default_nettype wire

[hdl/rss_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rss_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_point_x_mm,
  input wire logic [31:0] out_point_y_mm,
  input wire logic [9:0]  out_sample_index,
  input wire logic        out_cluster_closed,
  input wire logic [9:0]  out_cluster_first,
  input wire logic [9:0]  out_cluster_last,
  input wire logic [7:0]  out_cluster_number
);

  // Reset empties the result register
  `RSS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // Hold a stalled result beat
  `RSS_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_point_x_mm) && $stable(out_point_y_mm) && $stable(out_sample_index) && $stable(out_cluster_closed), "stalled beat changed")

  // Drop cluster fields on beats that close nothing
  `RSS_ASSERT(a_open_zero, clk, rst_n, out_valid && !out_cluster_closed |-> out_cluster_first == 10'd0 && out_cluster_last == 10'd0 && out_cluster_number == 8'd0, "cluster fields set without close")

  // A cluster ends at this sample or the one before
  `RSS_ASSERT(a_close_last, clk, rst_n, out_valid && out_cluster_closed |-> out_cluster_last == out_sample_index || 10'(out_cluster_last + 10'd1) == out_sample_index, "cluster end not adjacent")

endmodule

bind range_scan_segmenter rss_checker u_rss_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_point_x_mm     (out_ch.point_x_mm),
  .out_point_y_mm     (out_ch.point_y_mm),
  .out_sample_index   (out_ch.sample_index),
  .out_cluster_closed (out_ch.cluster_closed),
  .out_cluster_first  (out_ch.cluster_first),
  .out_cluster_last   (out_ch.cluster_last),
  .out_cluster_number (out_ch.cluster_number)
);

`default_nettype wire

[verif/range_scan_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of range_scan_segmenter, predicts every result
// beat from the accepted sample beats and compares them in order.
module range_scan_checker (
  input  logic clk,
  input  logic rst_n,
  rss_in_if    in_mon,
  rss_out_if   out_mon,
  rss_cfg_if   cfg_mon,
  output int   mismatch_count,
  output int   pending_points
);

  // Quarter-turn sine polynomial, Q30
  localparam longint unsigned SINE_A = 64'd1686629713;
  localparam longint unsigned SINE_B = 64'd688904867;
  localparam longint unsigned SINE_C = 64'd76016977;
  localparam int              TRIG_FRAC = 15;
  localparam logic [15:0]     QUARTER_TURN = 16'h4000;

  localparam longint signed COORD_MAX = 64'sd2147483647;
  localparam longint signed COORD_MIN = -64'sd2147483648;

  localparam logic [9:0] MIN_CLOSE_PAIRS = 10'd2;
  localparam logic [9:0] PAIR_CAP        = 10'd1023;
  localparam logic [9:0] LAST_INDEX      = 10'd1023;
  localparam logic [15:0] THR_DEFAULT    = 16'd100;
  localparam logic [15:0] STEP_DEFAULT   = 16'd182;
  localparam int REPORT_LIMIT            = 10;

  typedef struct packed {
    logic signed [31:0] x_mm;
    logic signed [31:0] y_mm;
    logic [9:0]         sample_idx;
    logic               closed;
    logic [9:0]         first_idx;
    logic [9:0]         last_idx;
    logic [7:0]         number;
  } scan_point_t;

  // Register copies
  logic [15:0]        close_thr;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0]        heading;
  logic [15:0]        step;

  // Scan state
  logic [15:0] prev_range;
  logic [9:0]  next_index;
  logic [9:0]  pair_count;
  logic [9:0]  run_first;
  logic [7:0]  cluster_no;

  scan_point_t expected_points[$];

  function automatic longint unsigned quarter_sine(longint unsigned q);
    longint unsigned x, x2, t;
    x  = q << 16;
    x2 = (x * x) >> 30;
    t  = SINE_B - ((x2 * SINE_C) >> 30);
    t  = SINE_A - ((x2 * t) >> 30);
    return (x * t) >> 30;
  endfunction

  // Sine of a binary angle, rounded to TRIG_FRAC fraction bits
  function automatic longint signed binary_sine(logic [15:0] ang);
    longint unsigned q, s;
    q = ang[13:0];
    if (ang[14]) q = 64'd16384 - q;
    s = (quarter_sine(q) + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC);
    return ang[15] ? -longint'(s) : longint'(s);
  endfunction

  // Scale range by trig, round half away from zero, add pose, saturate
  function automatic logic signed [31:0] world_coord(logic signed [31:0] pose,
                                                    logic [15:0] range,
                                                    longint signed trig);
    longint unsigned mag, prod;
    longint signed   r, v;
    mag  = (trig < 0) ? -trig : trig;
    prod = range * mag;
    r    = longint'((prod + (64'd1 << (TRIG_FRAC - 1))) >> TRIG_FRAC);
    if (trig < 0) r = -r;
    v = longint'(pose) + r;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v[31:0];
  endfunction

  // Build the result for one sample and advance the scan state
  function automatic scan_point_t predict_point(logic [15:0] range, logic last_flag);
    scan_point_t p;
    logic [9:0]  idx;
    logic [15:0] ang, cos_ang, diff;
    idx     = next_index;
    ang     = heading + idx * step;
    cos_ang = ang + QUARTER_TURN;
    p = '0;
    p.x_mm       = world_coord(pose_x, range, binary_sine(cos_ang));
    p.y_mm       = world_coord(pose_y, range, binary_sine(ang));
    p.sample_idx = idx;

    // pair test against the previous sample
    if (idx != 0) begin
      diff = (range > prev_range) ? range - prev_range : prev_range - range;
      if (diff < close_thr) begin
        if (pair_count < PAIR_CAP) pair_count = pair_count + 1'b1;
      end else begin
        if (pair_count > MIN_CLOSE_PAIRS) begin
          p.closed    = 1'b1;
          p.first_idx = run_first;
          p.last_idx  = idx - 1'b1;
          p.number    = cluster_no;
          cluster_no  = cluster_no + 1'b1;
        end
        run_first  = idx;
        pair_count = '0;
      end
    end

    // scan end closes the trailing run, then clears the scan
    if (last_flag) begin
      if (!p.closed && pair_count > MIN_CLOSE_PAIRS) begin
        p.closed    = 1'b1;
        p.first_idx = run_first;
        p.last_idx  = idx;
        p.number    = cluster_no;
      end
      next_index = '0;
      pair_count = '0;
      run_first  = '0;
      cluster_no = '0;
      prev_range = '0;
    end else begin
      prev_range = range;
      if (idx < LAST_INDEX) next_index = idx + 1'b1;
    end
    return p;
  endfunction

  function automatic string show_point(scan_point_t p);
    return $sformatf("x=%0d y=%0d idx=%0d closed=%0b first=%0d last=%0d num=%0d",
                     p.x_mm, p.y_mm, p.sample_idx, p.closed, p.first_idx,
                     p.last_idx, p.number);
  endfunction

  always @(posedge clk) begin
    scan_point_t got, want;
    if (!rst_n) begin
      close_thr  = THR_DEFAULT;
      pose_x     = '0;
      pose_y     = '0;
      heading    = '0;
      step       = STEP_DEFAULT;
      prev_range = '0;
      next_index = '0;
      pair_count = '0;
      run_first  = '0;
      cluster_no = '0;
      expected_points.delete();
    end else begin
      // register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          rss_pkg::CFG_CLOSE_THRESHOLD: close_thr = cfg_mon.data[15:0];
          rss_pkg::CFG_POSE_X:          pose_x    = cfg_mon.data;
          rss_pkg::CFG_POSE_Y:          pose_y    = cfg_mon.data;
          rss_pkg::CFG_POSE_HEADING:    heading   = cfg_mon.data[15:0];
          rss_pkg::CFG_ANGLE_STEP:      step      = cfg_mon.data[15:0];
          default: ;
        endcase
      end

      // compare result beat with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.x_mm       = out_mon.point_x_mm;
        got.y_mm       = out_mon.point_y_mm;
        got.sample_idx = out_mon.sample_index;
        got.closed     = out_mon.cluster_closed;
        got.first_idx  = out_mon.cluster_first;
        got.last_idx   = out_mon.cluster_last;
        got.number     = out_mon.cluster_number;
        if (expected_points.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result beat with none pending: %s", $realtime,
                     show_point(got));
        end else begin
          want = expected_points.pop_front();
          if (got !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("%0t: point mismatch", $realtime);
              $display("  expected %s", show_point(want));
              $display("  actual   %s", show_point(got));
            end
          end
        end
      end

      // predict for each accepted sample beat, append at the tail
      if (in_mon.valid && in_mon.ready)
        expected_points.insert(expected_points.size(),
                               predict_point(in_mon.range_mm, in_mon.last_sample));
    end
    pending_points = expected_points.size();
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int          SETTLE_CYCLES  = 12;
  localparam int          DRAIN_LIMIT    = 5000;
  localparam int          BACKLOG_CYCLES = 80;
  localparam logic [2:0]  SPARE_CFG_INDEX = 3'd7;
  localparam int          CORNER_COUNT   = 23;

  // Directed samples: threshold edges, range extremes, short runs,
  // single-sample scan, clusters closed by a break and by the scan end
  localparam logic [15:0] CORNER_RANGE [CORNER_COUNT] = '{
    16'd0, 16'd0, 16'd99, 16'd199, 16'd199, 16'd200, 16'd201,
    16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65500, 16'd65534,
    16'd32768,
    16'd500, 16'd510, 16'd520, 16'd530, 16'd9000,
    16'd500, 16'd500, 16'd500, 16'd500
  };
  localparam bit CORNER_LAST [CORNER_COUNT] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b1,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1
  };

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_points;

  bit   calm;
  bit   backlog_hold;
  int   gap_odds;
  int   stim_thr;

  rss_in_if  in_ch ();
  rss_out_if out_ch ();
  rss_cfg_if cfg_ch ();

  range_scan_segmenter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  range_scan_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_mon        (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_points (pending_points)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one sample beat, with an optional idle burst first
  task automatic send_sample(input logic [15:0] r, input logic last_flag);
    if (!calm && !backlog_hold && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.range_mm    <= r;
    in_ch.last_sample <= last_flag;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Hold cfg valid high across consecutive writes
  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Write all registers; upper data bits of 16-bit registers carry junk
  task automatic write_settings(input logic [15:0] thr, input logic [31:0] px,
                                input logic [31:0] py, input logic [15:0] head,
                                input logic [15:0] ang_step);
    logic [15:0] junk;
    junk = 16'($urandom);
    write_reg(rss_pkg::CFG_CLOSE_THRESHOLD, {junk, thr});
    write_reg(rss_pkg::CFG_POSE_X, px);
    write_reg(rss_pkg::CFG_POSE_Y, py);
    junk = 16'($urandom);
    write_reg(rss_pkg::CFG_POSE_HEADING, {junk, head});
    junk = 16'($urandom);
    write_reg(rss_pkg::CFG_ANGLE_STEP, {junk, ang_step});
    // unmapped index must leave everything alone
    write_reg(SPARE_CFG_INDEX, $urandom);
    cfg_ch.valid <= 1'b0;
    stim_thr = int'(thr);
  endtask

  // Stop offering and wait until every result beat has arrived
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_points != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random scans built from runs of near-equal ranges, with some noise
  task automatic run_scans(input int budget, input int hold_at);
    int          sent, len, run_left, jitter, value;
    logic [15:0] base, r;
    sent     = 0;
    run_left = 0;
    base     = '0;
    while (sent < budget) begin
      len      = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 120) : $urandom_range(1, 30);
      if (len > budget - sent) len = budget - sent;
      gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 10);
      for (int i = 0; i < len; i++) begin
        if (sent == hold_at) backlog_hold = 1'b1;
        if (run_left == 0) begin
          base     = 16'($urandom);
          run_left = $urandom_range(1, 10);
        end
        run_left = run_left - 1;
        jitter   = (stim_thr > 1) ? $urandom_range(0, (stim_thr - 1) / 2) : 0;
        case ($urandom_range(0, 9))
          0: r = 16'($urandom);
          1: r = base;
          default: begin
            value = int'(base) + ($urandom_range(0, 1) ? jitter : -jitter);
            if (value < 0) value = 0;
            if (value > 65535) value = 65535;
            r = value[15:0];
          end
        endcase
        send_sample(r, i == len - 1);
        sent = sent + 1;
      end
    end
  endtask

  // Result side: random stall bursts and one long hold-off on request
  initial begin
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (backlog_hold) begin
        out_ch.ready <= 1'b0;
        repeat (BACKLOG_CYCLES) @(negedge clk);
        out_ch.ready <= 1'b1;
        backlog_hold = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  initial begin
    int drain_wait;
    in_ch.valid       = 1'b0;
    in_ch.range_mm    = '0;
    in_ch.last_sample = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = rss_pkg::CFG_CLOSE_THRESHOLD;
    cfg_ch.data       = '0;
    calm              = 1'b0;
    backlog_hold      = 1'b0;
    gap_odds          = 4;
    stim_thr          = 100;
    rst_n             = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed corners with reset register values
    for (int i = 0; i < CORNER_COUNT; i++) send_sample(CORNER_RANGE[i], CORNER_LAST[i]);
    settle();

    // zero threshold, pose x at its top and pose y at its bottom value, angles at their top values
    write_settings(16'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'hFFFF);
    run_scans(120, -1);
    settle();

    // widest threshold, opposite pose extremes, fixed angle
    write_settings(16'hFFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h4000, 16'h0000);
    run_scans(120, -1);
    settle();

    // random registers, one long receiver hold-off
    write_settings(16'($urandom_range(1, 3000)), $urandom, $urandom,
                   16'($urandom), 16'($urandom));
    run_scans(180, 40);
    settle();

    // random registers, no idling on either side
    write_settings(16'($urandom_range(1, 3000)), $urandom, $urandom,
                   16'($urandom), 16'($urandom));
    calm = 1'b1;
    run_scans(180, -1);

    // drain
    in_ch.valid <= 1'b0;
    drain_wait = 0;
    while (pending_points != 0 && drain_wait < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_wait = drain_wait + 1;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_points == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
